// ===== rtl/core/crb_pkg.sv =====
// ----------------------------------------------------------------------------
// crb_pkg
// Shared types, constants and helpers for the color blend ramp pipeline.
// ----------------------------------------------------------------------------
package crb_pkg;

  localparam int unsigned CHAN_W  = 8;
  localparam int unsigned NCHAN   = 3;
  localparam int unsigned PROD_W  = 2 * CHAN_W;
  localparam int unsigned NUM_W   = 3 * CHAN_W;
  localparam int unsigned IDX_W   = 3;
  localparam logic [CHAN_W-1:0] FULL_SCALE = 8'd255;

  typedef enum logic [IDX_W-1:0] {
    REG_FG_RED   = 3'd0,
    REG_FG_GREEN = 3'd1,
    REG_FG_BLUE  = 3'd2,
    REG_BG_RED   = 3'd3,
    REG_BG_GREEN = 3'd4,
    REG_BG_BLUE  = 3'd5,
    REG_TRANS    = 3'd6
  } reg_idx_t;

  typedef struct packed {
    logic [NCHAN-1:0][CHAN_W-1:0] fg;
    logic [NCHAN-1:0][CHAN_W-1:0] bg;
    logic [CHAN_W-1:0]            trans;
  } cfg_regs_t;

  typedef struct packed {
    logic [NCHAN-1:0][NUM_W-1:0]  rem;
    logic [NCHAN-1:0][CHAN_W-1:0] quo;
    logic [PROD_W-1:0]            den;
  } div_t;

  typedef struct packed {
    logic [NCHAN-1:0][CHAN_W-1:0] opaque;
    logic [CHAN_W-1:0]            alpha;
    logic                         dzero;
  } carry_t;

  // floor(x/255) for x <= 255*255
  function automatic logic [CHAN_W-1:0] div255(input logic [PROD_W-1:0] x);
    logic [PROD_W:0] s;
    s = {1'b0, x} + (PROD_W + 1)'(x[PROD_W-1:CHAN_W]) + (PROD_W + 1)'(1);
    return s[PROD_W-1:CHAN_W];
  endfunction

endpackage

// ===== rtl/core/crb_front.sv =====
// ----------------------------------------------------------------------------
// crb_front
// Product and sum stages: linear mix, composite numerators and divisor.
// ----------------------------------------------------------------------------
module crb_front import crb_pkg::*; (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              en,
  input  logic              in_valid,
  input  logic [CHAN_W-1:0] level,
  input  cfg_regs_t         cfg,
  output logic              valid_out,
  output div_t              div_out,
  output carry_t            carry_out
);

  logic                          v1_r, v2_r;
  logic [NCHAN-1:0][PROD_W-1:0]  pf_r, pb_r;
  logic [PROD_W-1:0]             d_r;
  div_t                          div_r;
  carry_t                        carry_r;
  logic [CHAN_W-1:0]             inv;

  assign inv = FULL_SCALE - level;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
    end else if (en) begin
      v1_r <= in_valid;
      v2_r <= v1_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int c = 0; c < NCHAN; c++) begin
        pf_r[c] <= cfg.fg[c] * level;
        pb_r[c] <= cfg.bg[c] * inv;
      end
      d_r <= (FULL_SCALE * level) + (cfg.trans * inv);
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int c = 0; c < NCHAN; c++) begin
        carry_r.opaque[c] <= div255(pf_r[c] + pb_r[c]);
        div_r.rem[c]      <= ({pf_r[c], {CHAN_W{1'b0}}} - NUM_W'(pf_r[c]))
                           + (NUM_W'(pb_r[c]) * NUM_W'(cfg.trans));
        div_r.quo[c]      <= '0;
      end
      div_r.den     <= d_r;
      carry_r.alpha <= div255(d_r);
      carry_r.dzero <= (d_r == '0);
    end
  end

  assign valid_out = v2_r;
  assign div_out   = div_r;
  assign carry_out = carry_r;

endmodule

// ===== rtl/core/crb_div_step.sv =====
// ----------------------------------------------------------------------------
// crb_div_step
// One restoring division stage: resolves one quotient bit per channel.
// ----------------------------------------------------------------------------
module crb_div_step import crb_pkg::*; #(
  parameter int unsigned BIT_POS = 0
) (
  input  logic   clk,
  input  logic   rst_n,
  input  logic   en,
  input  logic   valid_in,
  input  div_t   div_in,
  input  carry_t carry_in,
  output logic   valid_out,
  output div_t   div_out,
  output carry_t carry_out
);

  logic              valid_r;
  div_t              div_r, div_nxt;
  carry_t            carry_r;
  logic [NUM_W-1:0]  trial;

  assign trial = NUM_W'(div_in.den) << BIT_POS;

  always_comb begin
    div_nxt = div_in;
    for (int c = 0; c < NCHAN; c++) begin
      if (div_in.rem[c] >= trial) begin
        div_nxt.rem[c]          = div_in.rem[c] - trial;
        div_nxt.quo[c][BIT_POS] = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (en) begin
      valid_r <= valid_in;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      div_r   <= div_nxt;
      carry_r <= carry_in;
    end
  end

  assign valid_out = valid_r;
  assign div_out   = div_r;
  assign carry_out = carry_r;

endmodule

// ===== rtl/core/color_blend_ramp_unit.sv =====
// ----------------------------------------------------------------------------
// color_blend_ramp_unit
// Per-level color ramp entry: opaque linear mix and translucent composite.
// ----------------------------------------------------------------------------
// One level enters per cycle while the pipeline is not held; its result passes
// through two product/sum stages followed by eight restoring division stages,
// one quotient bit each, that divide the composite numerators by the coverage
// divisor. The whole pipeline holds while a finished result is not taken.
// Write the configuration registers only while the pipeline is empty.
module color_blend_ramp_unit import crb_pkg::*; (
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic                    in_tvalid,
  output logic                    in_tready,
  input  logic [CHAN_W-1:0]       in_tdata,   // [7:0] level
  output logic                    out_tvalid,
  input  logic                    out_tready,
  // [7:0] opaque_red, [15:8] opaque_green, [23:16] opaque_blue,
  // [31:24] blend_red, [39:32] blend_green, [47:40] blend_blue,
  // [55:48] blend_alpha
  output logic [7*CHAN_W-1:0]     out_tdata,
  input  logic                    cfg_valid,
  output logic                    cfg_ready,
  input  logic [IDX_W-1:0]        cfg_index,
  input  logic [CHAN_W-1:0]       cfg_data
);

  cfg_regs_t cfg_r;
  logic      adv;

  logic   [CHAN_W:0] vld;
  div_t   [CHAN_W:0] dv;
  carry_t [CHAN_W:0] cy;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.fg    <= '0;
      cfg_r.bg    <= {NCHAN{FULL_SCALE}};
      cfg_r.trans <= FULL_SCALE;
    end else if (cfg_valid) begin
      unique case (reg_idx_t'(cfg_index))
        REG_FG_RED:   cfg_r.fg[0]  <= cfg_data;
        REG_FG_GREEN: cfg_r.fg[1]  <= cfg_data;
        REG_FG_BLUE:  cfg_r.fg[2]  <= cfg_data;
        REG_BG_RED:   cfg_r.bg[0]  <= cfg_data;
        REG_BG_GREEN: cfg_r.bg[1]  <= cfg_data;
        REG_BG_BLUE:  cfg_r.bg[2]  <= cfg_data;
        REG_TRANS:    cfg_r.trans  <= cfg_data;
        default: ;
      endcase
    end
  end

  // hold everything while the output register is full and not taken
  assign adv       = !vld[CHAN_W] || out_tready;
  assign in_tready = adv;

  crb_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .en        (adv),
    .in_valid  (in_tvalid),
    .level     (in_tdata),
    .cfg       (cfg_r),
    .valid_out (vld[0]),
    .div_out   (dv[0]),
    .carry_out (cy[0])
  );

  for (genvar s = 0; s < CHAN_W; s++) begin : g_div
    crb_div_step #(.BIT_POS(CHAN_W - 1 - s)) u_step (
      .clk       (clk),
      .rst_n     (rst_n),
      .en        (adv),
      .valid_in  (vld[s]),
      .div_in    (dv[s]),
      .carry_in  (cy[s]),
      .valid_out (vld[s+1]),
      .div_out   (dv[s+1]),
      .carry_out (cy[s+1])
    );
  end

  assign out_tvalid = vld[CHAN_W];

  always_comb begin
    for (int c = 0; c < NCHAN; c++) begin
      out_tdata[c*CHAN_W +: CHAN_W]           = cy[CHAN_W].opaque[c];
      out_tdata[(c+NCHAN)*CHAN_W +: CHAN_W]   = cy[CHAN_W].dzero ? '0
                                                : dv[CHAN_W].quo[c];
    end
    out_tdata[2*NCHAN*CHAN_W +: CHAN_W] = cy[CHAN_W].alpha;
  end

endmodule
